[rtl/mrcu_pkg.sv]
package mrcu_pkg;

  localparam int DATA_DEPTH_DEF  = 256;
  localparam int INSTR_DEPTH_DEF = 256;
  localparam int REG_COUNT       = 8;
  localparam int WORD_W          = 32;

  localparam logic [1:0] OPER_EXEC = 2'd0;
  localparam logic [1:0] OPER_LOAD = 2'd1;
  localparam logic [1:0] OPER_READ = 2'd2;
  localparam logic [1:0] OPER_UNDO = 2'd3;

  localparam logic [3:0] OPC_RTYPE = 4'd0;
  localparam logic [3:0] OPC_J     = 4'd2;
  localparam logic [3:0] OPC_ADDI  = 4'd4;
  localparam logic [3:0] OPC_BEQ   = 4'd8;
  localparam logic [3:0] OPC_LW    = 4'd11;
  localparam logic [3:0] OPC_SW    = 4'd15;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_REG  = 2'd1;
  localparam logic [1:0] KIND_MEM  = 2'd2;

  typedef logic [WORD_W-1:0] word_t;

endpackage

[rtl/mrcu_dmem.sv]
module mrcu_dmem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/mini_risc_core_with_undo.sv]
// Mini 16-bit RISC core with a one-level undo. Each transfer on the in_ channel is one
// operation (execute an instruction, load a data word, read a data word, undo the last
// instruction) and gives exactly one transfer on the out_ channel. The core sustains one
// operation per clock cycle while out_stall stays low; a result passes from the input stage
// through the execute stage into the output register, the data memory read being the
// middle stage. Register and memory dependences between back-to-back operations are
// bypassed, so apart from the clear sweep the core never stalls on its own. After reset
// the data memory is zeroed by a sweep, one word per cycle through its single write port;
// in_stall stays high until it ends. DATA_DEPTH and INSTR_DEPTH must be powers of two.
module mini_risc_core_with_undo
  import mrcu_pkg::*;
#(
  parameter int DATA_DEPTH  = DATA_DEPTH_DEF,
  parameter int INSTR_DEPTH = INSTR_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_instr_word,
  input  logic [7:0]         in_data_address,
  input  logic signed [31:0] in_data_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_next_pc,
  output logic               out_reg_written,
  output logic [2:0]         out_dest_reg,
  output logic signed [31:0] out_dest_value,
  output logic               out_mem_written,
  output logic               out_branch_taken,
  output logic signed [31:0] out_read_value
);

  localparam int AW = $clog2(DATA_DEPTH);
  localparam int PW = $clog2(INSTR_DEPTH);

  // input stage
  logic        s1_vld_r;
  logic [1:0]  s1_op_r;
  logic [15:0] s1_iw_r;
  logic [7:0]  s1_addr_r;
  word_t       s1_dval_r;

  // execute stage
  logic          s2_vld_r;
  logic [1:0]    s2_op_r;
  logic [15:0]   s2_iw_r;
  logic [AW-1:0] s2_addr_r;
  word_t         s2_dval_r;
  logic          s2_hit_r;
  word_t         s2_hitd_r;

  // result register
  logic        out_vld_r;
  logic [7:0]  out_pc_r;
  logic        out_rw_r;
  logic [2:0]  out_dr_r;
  word_t       out_dval_r;
  logic        out_mw_r;
  logic        out_bt_r;
  word_t       out_rv_r;

  // architectural state
  word_t         rf_r [REG_COUNT];
  logic [PW-1:0] pc_r, pc_nxt;
  logic [PW-1:0] upc_r, upc_nxt;
  logic [1:0]    ukind_r, ukind_nxt;
  logic [AW-1:0] uidx_r, uidx_nxt;
  word_t         uold_r, uold_nxt;

  logic          clr_r;
  logic [AW-1:0] clr_cnt_r;

  logic out_go, s2_go, s1_go, in_go;

  assign out_go   = out_vld_r && !out_stall;
  assign s2_go    = s2_vld_r && (!out_vld_r || !out_stall);
  assign s1_go    = s1_vld_r && (!s2_vld_r || s2_go);
  assign in_stall = clr_r || (s1_vld_r && !s1_go);
  assign in_go    = in_valid && !in_stall;

  logic [WORD_W-1:0] mem_rdata;

  // execute stage logic
  logic [3:0]      x_opc;
  logic [2:0]      x_rs, x_rt, x_rd, x_fn;
  logic [5:0]      x_off;
  word_t           x_imm, x_a, x_b, x_mval;
  logic [PW-1:0]   x_pc_inc;
  logic [PW+5:0]   x_beq_sum;
  logic [PW+11:0]  x_jt_w;
  logic            rf_we;
  logic [2:0]      rf_wa;
  word_t           rf_wd;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  word_t           mem_wd;
  logic            r_wr;
  logic [2:0]      r_dst;
  word_t           r_res;
  logic            x_rw, x_mw, x_bt;
  logic [2:0]      x_dr;
  word_t           x_dval, x_rv;

  always_comb begin
    x_opc     = s2_iw_r[15:12];
    x_rs      = s2_iw_r[11:9];
    x_rt      = s2_iw_r[8:6];
    x_rd      = s2_iw_r[5:3];
    x_fn      = s2_iw_r[2:0];
    x_off     = s2_iw_r[5:0];
    x_imm     = {{(WORD_W-6){x_off[5]}}, x_off};
    x_a       = rf_r[x_rs];
    x_b       = rf_r[x_rt];
    x_mval    = s2_hit_r ? s2_hitd_r : word_t'(mem_rdata);
    x_pc_inc  = pc_r + PW'(1);
    x_beq_sum = (PW+6)'(x_pc_inc) + (PW+6)'(x_off);
    x_jt_w    = (PW+12)'(s2_iw_r[11:0]);

    pc_nxt    = pc_r;
    upc_nxt   = upc_r;
    ukind_nxt = ukind_r;
    uidx_nxt  = uidx_r;
    uold_nxt  = uold_r;
    rf_we     = 1'b0;
    rf_wa     = '0;
    rf_wd     = '0;
    mem_we    = 1'b0;
    mem_wa    = s2_addr_r;
    mem_wd    = '0;
    r_wr      = 1'b0;
    r_dst     = '0;
    r_res     = '0;
    x_rw      = 1'b0;
    x_dr      = '0;
    x_dval    = '0;
    x_mw      = 1'b0;
    x_bt      = 1'b0;
    x_rv      = '0;

    case (s2_op_r)
      OPER_EXEC: begin
        upc_nxt   = pc_r;
        ukind_nxt = KIND_NONE;
        pc_nxt    = x_pc_inc;
        case (x_opc)
          OPC_RTYPE: begin
            r_dst = x_rd;
            case (x_fn)
              FN_ADD: begin
                r_wr  = 1'b1;
                r_res = x_a + x_b;
              end
              FN_SUB: begin
                r_wr  = 1'b1;
                r_res = x_a - x_b;
              end
              FN_AND: begin
                r_wr  = 1'b1;
                r_res = x_a & x_b;
              end
              FN_OR: begin
                r_wr  = 1'b1;
                r_res = x_a | x_b;
              end
              default: r_wr = 1'b0;
            endcase
          end
          OPC_ADDI: begin
            r_wr  = 1'b1;
            r_dst = x_rt;
            r_res = x_a + x_imm;
          end
          OPC_LW: begin
            r_wr  = 1'b1;
            r_dst = x_rt;
            r_res = x_mval;
          end
          OPC_SW: begin
            ukind_nxt = KIND_MEM;
            uidx_nxt  = s2_addr_r;
            uold_nxt  = x_mval;
            mem_we    = 1'b1;
            mem_wd    = x_b;
            x_mw      = 1'b1;
            x_dval    = x_b;
          end
          OPC_BEQ: begin
            if (x_a == x_b) begin
              pc_nxt = x_beq_sum[PW-1:0];
              x_bt   = 1'b1;
            end
          end
          OPC_J: begin
            pc_nxt = x_jt_w[PW-1:0];
            x_bt   = 1'b1;
          end
          default: pc_nxt = x_pc_inc;
        endcase
        if (r_wr) begin
          ukind_nxt = KIND_REG;
          uidx_nxt  = AW'(r_dst);
          uold_nxt  = rf_r[r_dst];
          if (r_dst != '0) begin
            rf_we  = 1'b1;
            rf_wa  = r_dst;
            rf_wd  = r_res;
            x_rw   = 1'b1;
            x_dr   = r_dst;
            x_dval = r_res;
          end
        end
      end
      OPER_LOAD: begin
        mem_we = 1'b1;
        mem_wd = s2_dval_r;
        x_mw   = 1'b1;
        x_dval = s2_dval_r;
      end
      OPER_READ: begin
        x_rv = x_mval;
      end
      OPER_UNDO: begin
        pc_nxt = upc_r;
        case (ukind_r)
          KIND_REG: begin
            if (uidx_r[2:0] != '0) begin
              rf_we  = 1'b1;
              rf_wa  = uidx_r[2:0];
              rf_wd  = uold_r;
              x_rw   = 1'b1;
              x_dr   = uidx_r[2:0];
              x_dval = uold_r;
            end
          end
          KIND_MEM: begin
            mem_we = 1'b1;
            mem_wa = uidx_r;
            mem_wd = uold_r;
            x_mw   = 1'b1;
            x_dval = uold_r;
          end
          default: x_mw = 1'b0;
        endcase
      end
      default: pc_nxt = pc_r;
    endcase
  end

  // input stage: address generation with bypass from the execute stage
  word_t         s1_a;
  word_t         s1_ea_w;
  logic [AW+7:0] s1_da_w;
  logic [AW-1:0] s1_raddr;
  logic          s1_hit_nxt;

  always_comb begin
    if (s2_go && rf_we && (rf_wa == s1_iw_r[11:9])) begin
      s1_a = rf_wd;
    end else begin
      s1_a = rf_r[s1_iw_r[11:9]];
    end
    s1_ea_w = s1_a + word_t'(s1_iw_r[5:0]);
    s1_da_w = (AW+8)'(s1_addr_r);
    if (s1_op_r == OPER_EXEC) begin
      s1_raddr = s1_ea_w[AW-1:0];
    end else begin
      s1_raddr = s1_da_w[AW-1:0];
    end
    s1_hit_nxt = s2_go && mem_we && (mem_wa == s1_raddr);
  end

  // data memory
  logic          dm_we;
  logic [AW-1:0] dm_wa;
  word_t         dm_wd;

  assign dm_we = clr_r || (s2_go && mem_we);
  assign dm_wa = clr_r ? clr_cnt_r : mem_wa;
  assign dm_wd = clr_r ? '0 : mem_wd;

  mrcu_dmem #(
    .DEPTH (DATA_DEPTH),
    .WIDTH (WORD_W)
  ) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_wa),
    .wdata (dm_wd),
    .re    (s1_go),
    .raddr (s1_raddr),
    .rdata (mem_rdata)
  );

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= '0;
      upc_r     <= '0;
      ukind_r   <= KIND_NONE;
      uidx_r    <= '0;
      uold_r    <= '0;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        rf_r[i] <= '0;
      end
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DATA_DEPTH - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (in_go) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_go) begin
        s2_vld_r <= 1'b1;
      end else if (s2_go) begin
        s2_vld_r <= 1'b0;
      end
      if (s2_go) begin
        out_vld_r <= 1'b1;
      end else if (out_go) begin
        out_vld_r <= 1'b0;
      end
      if (s2_go) begin
        pc_r    <= pc_nxt;
        upc_r   <= upc_nxt;
        ukind_r <= ukind_nxt;
        uidx_r  <= uidx_nxt;
        uold_r  <= uold_nxt;
        if (rf_we) begin
          rf_r[rf_wa] <= rf_wd;
        end
      end
    end
  end

  // payload registers
  logic [PW+7:0] pc_out_w;
  assign pc_out_w = (PW+8)'(pc_nxt);

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_op_r   <= in_operation;
      s1_iw_r   <= in_instr_word;
      s1_addr_r <= in_data_address;
      s1_dval_r <= in_data_value;
    end
    if (s1_go) begin
      s2_op_r   <= s1_op_r;
      s2_iw_r   <= s1_iw_r;
      s2_addr_r <= s1_raddr;
      s2_dval_r <= s1_dval_r;
      s2_hit_r  <= s1_hit_nxt;
      s2_hitd_r <= mem_wd;
    end
    if (s2_go) begin
      out_pc_r   <= pc_out_w[7:0];
      out_rw_r   <= x_rw;
      out_dr_r   <= x_dr;
      out_dval_r <= x_dval;
      out_mw_r   <= x_mw;
      out_bt_r   <= x_bt;
      out_rv_r   <= x_rv;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_next_pc      = out_pc_r;
  assign out_reg_written  = out_rw_r;
  assign out_dest_reg     = out_dr_r;
  assign out_dest_value   = out_dval_r;
  assign out_mem_written  = out_mw_r;
  assign out_branch_taken = out_bt_r;
  assign out_read_value   = out_rv_r;

  a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (!s1_vld_r && !s2_vld_r && !out_vld_r))
    else $error("item in flight during memory clear");

  a_zero_reg: assert property (@(posedge clk) disable iff (!rst_n)
    rf_r[0] == '0)
    else $error("register zero was written");

  a_dest_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_rw_r) |-> (out_dr_r != '0))
    else $error("register write reported for register zero");

  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_rw_r && out_mw_r))
    else $error("result writes both register and memory");

endmodule

[tb/mini_risc_core_with_undo_scoreboard.sv]
module mini_risc_core_with_undo_scoreboard
  import mrcu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_instr_word,
  input  logic [7:0]         in_data_address,
  input  logic signed [31:0] in_data_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         out_next_pc,
  input  logic               out_reg_written,
  input  logic [2:0]         out_dest_reg,
  input  logic signed [31:0] out_dest_value,
  input  logic               out_mem_written,
  input  logic               out_branch_taken,
  input  logic signed [31:0] out_read_value,
  output int                 fail_count,
  output int                 results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] next_pc;
    logic       reg_written;
    logic [2:0] dest_reg;
    word_t      dest_value;
    logic       mem_written;
    logic       branch_taken;
    word_t      read_value;
  } core_result_t;

  word_t      gpr [REG_COUNT];
  word_t      dmem [DATA_DEPTH_DEF];
  logic [7:0] pc;
  logic [7:0] undo_pc;
  logic [1:0] undo_kind;
  logic [7:0] undo_index;
  word_t      undo_old;

  core_result_t results_due [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                results_seen, name, got, want));
  endtask

  task automatic execute_core_op(input logic [1:0] oper, input logic [15:0] iw,
                                 input logic [7:0] addr, input word_t value,
                                 output core_result_t r);
    logic [3:0] opc;
    logic [2:0] rs, rt, rd, fn, dst;
    logic [5:0] off;
    logic [7:0] ea;
    word_t      imm, a, b, res;
    bit         wr;
    r = '0;
    case (oper)
      OPER_EXEC: begin
        opc = iw[15:12];
        rs  = iw[11:9];
        rt  = iw[8:6];
        rd  = iw[5:3];
        fn  = iw[2:0];
        off = iw[5:0];
        imm = {{26{off[5]}}, off};
        a   = gpr[rs];
        b   = gpr[rt];
        dst = '0;
        res = '0;
        wr  = 1'b0;
        undo_pc   = pc;
        undo_kind = KIND_NONE;
        pc        = pc + 8'd1;
        case (opc)
          OPC_RTYPE: begin
            dst = rd;
            wr  = 1'b1;
            case (fn)
              FN_ADD:  res = a + b;
              FN_SUB:  res = a - b;
              FN_AND:  res = a & b;
              FN_OR:   res = a | b;
              default: wr = 1'b0;
            endcase
          end
          OPC_ADDI: begin
            dst = rt;
            res = a + imm;
            wr  = 1'b1;
          end
          OPC_LW: begin
            ea  = a[7:0] + {2'b00, off};
            dst = rt;
            res = dmem[ea];
            wr  = 1'b1;
          end
          OPC_SW: begin
            ea         = a[7:0] + {2'b00, off};
            undo_kind  = KIND_MEM;
            undo_index = ea;
            undo_old   = dmem[ea];
            dmem[ea]   = b;
            r.mem_written = 1'b1;
            r.dest_value  = b;
          end
          OPC_BEQ: begin
            if (a == b) begin
              pc = pc + {2'b00, off};
              r.branch_taken = 1'b1;
            end
          end
          OPC_J: begin
            pc = iw[7:0];
            r.branch_taken = 1'b1;
          end
          default: ;
        endcase
        if (wr) begin
          undo_kind  = KIND_REG;
          undo_index = {5'd0, dst};
          undo_old   = gpr[dst];
          if (dst != 3'd0) begin
            gpr[dst]      = res;
            r.reg_written = 1'b1;
            r.dest_reg    = dst;
            r.dest_value  = res;
          end
        end
      end
      OPER_LOAD: begin
        dmem[addr]    = value;
        r.mem_written = 1'b1;
        r.dest_value  = value;
      end
      OPER_READ: r.read_value = dmem[addr];
      OPER_UNDO: begin
        pc = undo_pc;
        if (undo_kind == KIND_REG) begin
          if (undo_index[2:0] != 3'd0) begin
            gpr[undo_index[2:0]] = undo_old;
            r.reg_written = 1'b1;
            r.dest_reg    = undo_index[2:0];
            r.dest_value  = undo_old;
          end
        end else if (undo_kind == KIND_MEM) begin
          dmem[undo_index] = undo_old;
          r.mem_written    = 1'b1;
          r.dest_value     = undo_old;
        end
      end
    endcase
    r.next_pc = pc;
  endtask

  always @(posedge clk) begin : track
    core_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
      for (int i = 0; i < DATA_DEPTH_DEF; i++) dmem[i] = '0;
      pc         = '0;
      undo_pc    = '0;
      undo_kind  = KIND_NONE;
      undo_index = '0;
      undo_old   = '0;
      results_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        execute_core_op(in_operation, in_instr_word, in_data_address, in_data_value, want);
        results_due.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected, next_pc %h",
                                    out_next_pc));
        end else begin
          want = results_due.pop_front();
          compare_field("next_pc", out_next_pc, want.next_pc);
          compare_field("reg_written", out_reg_written, want.reg_written);
          compare_field("dest_reg", out_dest_reg, want.dest_reg);
          compare_field("dest_value", out_dest_value, want.dest_value);
          compare_field("mem_written", out_mem_written, want.mem_written);
          compare_field("branch_taken", out_branch_taken, want.branch_taken);
          compare_field("read_value", out_read_value, want.read_value);
          results_seen++;
        end
      end
    end
  end

endmodule

[tb/mini_risc_core_with_undo_tb.sv]
module mini_risc_core_with_undo_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mrcu_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 10;
  localparam int PHASE_ITEMS    = 90;

  localparam logic [3:0] OPC_UNUSED = 4'd1;
  localparam logic [2:0] FN_UNUSED  = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_operation;
  logic [15:0]        in_instr_word;
  logic [7:0]         in_data_address;
  logic signed [31:0] in_data_value;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_next_pc;
  logic               out_reg_written;
  logic [2:0]         out_dest_reg;
  logic signed [31:0] out_dest_value;
  logic               out_mem_written;
  logic               out_branch_taken;
  logic signed [31:0] out_read_value;

  int fail_count;
  int results_seen;
  int items_sent;
  int sender_idle_pct;
  int receiver_stall_pct;
  int quiet_cycles;
  bit hold_off_req;

  mini_risc_core_with_undo dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_instr_word    (in_instr_word),
    .in_data_address  (in_data_address),
    .in_data_value    (in_data_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_next_pc      (out_next_pc),
    .out_reg_written  (out_reg_written),
    .out_dest_reg     (out_dest_reg),
    .out_dest_value   (out_dest_value),
    .out_mem_written  (out_mem_written),
    .out_branch_taken (out_branch_taken),
    .out_read_value   (out_read_value)
  );

  mini_risc_core_with_undo_scoreboard scoreboard (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_instr_word    (in_instr_word),
    .in_data_address  (in_data_address),
    .in_data_value    (in_data_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_next_pc      (out_next_pc),
    .out_reg_written  (out_reg_written),
    .out_dest_reg     (out_dest_reg),
    .out_dest_value   (out_dest_value),
    .out_mem_written  (out_mem_written),
    .out_branch_taken (out_branch_taken),
    .out_read_value   (out_read_value),
    .fail_count       (fail_count),
    .results_seen     (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] enc_r(input logic [2:0] rs, input logic [2:0] rt,
                                        input logic [2:0] rd, input logic [2:0] fn);
    return {OPC_RTYPE, rs, rt, rd, fn};
  endfunction

  function automatic logic [15:0] enc_i(input logic [3:0] opc, input logic [2:0] rs,
                                        input logic [2:0] rt, input logic [5:0] off);
    return {opc, rs, rt, off};
  endfunction

  function automatic logic [15:0] enc_j(input logic [11:0] target);
    return {OPC_J, target};
  endfunction

  function automatic logic [15:0] rand_instr();
    logic [2:0] rs, rt, rd;
    logic [5:0] off;
    rs  = 3'($urandom_range(7));
    rt  = ($urandom_range(1) == 0) ? rs : 3'($urandom_range(7));
    rd  = 3'($urandom_range(7));
    off = 6'($urandom_range(63));
    case ($urandom_range(8))
      0:       return enc_r(rs, rt, rd, FN_ADD);
      1:       return enc_r(rs, rt, rd, FN_SUB);
      2:       return enc_r(rs, rt, rd, FN_AND);
      3:       return enc_r(rs, rt, rd, FN_OR);
      4:       return enc_i(OPC_ADDI, rs, rt, off);
      5:       return enc_i(OPC_LW, rs, rt, off);
      6:       return enc_i(OPC_SW, rs, rt, off);
      7:       return enc_i(OPC_BEQ, rs, rt, off);
      default: return enc_j(12'($urandom_range(4095)));
    endcase
  endfunction

  task automatic send_item(input logic [1:0] oper, input logic [15:0] iw,
                           input logic [7:0] addr, input logic [31:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= oper;
    in_instr_word   <= iw;
    in_data_address <= addr;
    in_data_value   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55)
      send_item(OPER_EXEC, rand_instr(), 8'($urandom), $urandom);
    else if (pick < 65)
      send_item(OPER_EXEC, 16'($urandom), 8'($urandom), $urandom);
    else if (pick < 78)
      send_item(OPER_LOAD, 16'($urandom), 8'($urandom), $urandom);
    else if (pick < 90)
      send_item(OPER_READ, 16'($urandom), 8'($urandom), $urandom);
    else
      send_item(OPER_UNDO, 16'($urandom), 8'($urandom), $urandom);
  endtask

  // hold off for a long stretch on request, else stall at the phase rate
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase  = '{0, 64, 0, 34};
    stall_by_phase = '{0, 0, 64, 34};
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_req       = 1'b0;
    items_sent         = 0;
    quiet_cycles       = 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_operation    <= OPER_EXEC;
    in_instr_word   <= '0;
    in_data_address <= '0;
    in_data_value   <= '0;
    out_stall       <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_item(OPER_UNDO, 16'h0000, 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_i(OPC_ADDI, 3'd0, 3'd1, 6'h20), 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_i(OPC_ADDI, 3'd0, 3'd2, 6'h1F), 8'h00, 32'h0);
    send_item(OPER_LOAD, 16'hFFFF, 8'hFF, 32'h7FFF_FFFF);
    send_item(OPER_LOAD, 16'h0000, 8'h00, 32'h8000_0000);
    send_item(OPER_EXEC, enc_i(OPC_LW, 3'd1, 3'd3, 6'h20), 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_i(OPC_LW, 3'd2, 3'd4, 6'h3F), 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_r(3'd3, 3'd1, 3'd5, FN_ADD), 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_r(3'd1, 3'd3, 3'd6, FN_SUB), 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_r(3'd3, 3'd1, 3'd7, FN_AND), 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_r(3'd1, 3'd2, 3'd7, FN_OR), 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_r(3'd1, 3'd2, 3'd7, FN_UNUSED), 8'h00, 32'h0);
    send_item(OPER_EXEC, {OPC_UNUSED, 12'hFFF}, 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_r(3'd1, 3'd2, 3'd0, FN_ADD), 8'h00, 32'h0);
    send_item(OPER_UNDO, 16'h0000, 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_i(OPC_SW, 3'd1, 3'd1, 6'h20), 8'h00, 32'h0);
    send_item(OPER_READ, 16'h0000, 8'h00, 32'h0);
    send_item(OPER_UNDO, 16'h0000, 8'h00, 32'h0);
    send_item(OPER_READ, 16'h0000, 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_i(OPC_BEQ, 3'd0, 3'd0, 6'h3F), 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_i(OPC_BEQ, 3'd1, 3'd2, 6'h3F), 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_j(12'hFFF), 8'h00, 32'h0);
    send_item(OPER_EXEC, enc_i(OPC_ADDI, 3'd5, 3'd5, 6'h01), 8'h00, 32'h0);
    send_item(OPER_UNDO, 16'h0000, 8'h00, 32'h0);
    send_item(OPER_UNDO, 16'h0000, 8'h00, 32'h0);
    send_item(OPER_READ, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);

    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = idle_by_phase[p];
      receiver_stall_pct = stall_by_phase[p];
      repeat (PHASE_ITEMS) send_random_item();
    end

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_req       = 1'b1;
    repeat (40) send_random_item();
    in_valid <= 1'b0;

    while (results_seen < items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
